// ===== src/cstk_pkg.sv =====
// Shared types, constants and codes for the clip rectangle stack.
package cstk_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ENTRY_AW    = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int OUT_DEPTH_W = 5;
	localparam int SCREEN_W    = 15;
	localparam int COORD_W     = 16;
	localparam int EDGE_W      = COORD_W + 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [SCREEN_W-1:0] SCREEN_W_RESET = SCREEN_W'(1920);
	localparam logic [SCREEN_W-1:0] SCREEN_H_RESET = SCREEN_W'(1080);

	localparam logic [1:0] FN_PUSH = 2'd0;
	localparam logic [1:0] FN_POP  = 2'd1;
	localparam logic [1:0] FN_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

	typedef struct packed {
		logic [1:0]                func;
		logic signed [COORD_W-1:0] rect_x;
		logic signed [COORD_W-1:0] rect_y;
		logic signed [COORD_W-1:0] rect_width;
		logic signed [COORD_W-1:0] rect_height;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] clip_x;
		logic signed [COORD_W-1:0] clip_y;
		logic [COORD_W-1:0]        clip_width;
		logic [COORD_W-1:0]        clip_height;
		logic                      clip_nonempty;
		logic [OUT_DEPTH_W-1:0]    stack_depth;
		logic                      op_ignored;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COORD_W-1:0]        w;
		logic [COORD_W-1:0]        h;
	} rect_t;

	typedef struct packed {
		logic latch;
		logic edges;
		logic write;
		logic pop;
		logic load;
		logic ignored;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic at_one;
	} status_t;

endpackage

// ===== src/cstk_ctrl.sv =====
// Controller state machine for the clip rectangle stack.
module cstk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        func,
	input  cstk_pkg::status_t status,
	output cstk_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import cstk_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EDGE  = 3'd1;
	localparam logic [2:0] S_WRITE = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ignored_q;
	logic       ignored_d;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		ignored_d = ignored_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ignored_d = 1'b0;
					unique case (func)
						FN_PUSH: begin
							if (status.full) begin
								ignored_d = 1'b1;
								state_d   = S_DONE;
							end else begin
								state_d = S_EDGE;
							end
						end
						FN_POP: begin
							if (status.at_one) begin
								ignored_d = 1'b1;
								state_d   = S_DONE;
							end else begin
								state_d = S_POP;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_EDGE:  state_d = S_WRITE;
			S_WRITE: state_d = S_DONE;
			S_POP:   state_d = S_LOAD;
			S_LOAD:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ignored_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ignored_q <= ignored_d;
		end
	end

	always_comb begin
		cmd.latch   = accept;
		cmd.edges   = (state_q == S_EDGE);
		cmd.write   = (state_q == S_WRITE);
		cmd.pop     = (state_q == S_POP);
		cmd.load    = (state_q == S_LOAD);
		cmd.ignored = ignored_q;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== src/cstk_dp.sv =====
// Datapath: screen registers, stack memory, top entry and intersection.
module cstk_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cstk_pkg::req_t                     req,
	input  cstk_pkg::cmd_t                     cmd,
	input  logic                               cfg_we,
	input  logic [cstk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cstk_pkg::SCREEN_W-1:0]      cfg_data,
	output cstk_pkg::status_t                  status,
	output cstk_pkg::rsp_t                     rsp
);
	import cstk_pkg::*;

	logic [SCREEN_W-1:0]      scr_w_q;
	logic [SCREEN_W-1:0]      scr_h_q;
	logic [DEPTH_W-1:0]       depth_q;
	req_t                     req_q;
	rect_t                    top_q;
	rect_t                    rd_q;
	rect_t                    mem_q [STACK_DEPTH];
	rect_t                    screen;
	rect_t                    cur;
	rect_t                    isect;
	logic signed [EDGE_W-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [EDGE_W-1:0] ax, ay, ax2, ay2, bx, by, bx2, by2;
	logic signed [EDGE_W-1:0] dx, dy;
	logic [DEPTH_W-1:0]       pop_idx;
	logic [DEPTH_W+OUT_DEPTH_W-1:0] depth_ext;

	assign status.full   = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign status.at_one = (depth_q == DEPTH_W'(1));

	always_comb begin
		screen.x = '0;
		screen.y = '0;
		screen.w = {1'b0, scr_w_q};
		screen.h = {1'b0, scr_h_q};
		cur      = status.at_one ? screen : top_q;
	end

	// edge stage: overlap bounds of current top and pushed rectangle
	always_comb begin
		ax  = EDGE_W'(cur.x);
		ay  = EDGE_W'(cur.y);
		ax2 = ax + $signed({2'b00, cur.w});
		ay2 = ay + $signed({2'b00, cur.h});
		bx  = EDGE_W'(req_q.rect_x);
		by  = EDGE_W'(req_q.rect_y);
		bx2 = bx + EDGE_W'(req_q.rect_width);
		by2 = by + EDGE_W'(req_q.rect_height);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.edges) begin
			x1_s1 <= (ax > bx) ? ax : bx;
			y1_s1 <= (ay > by) ? ay : by;
			x2_s1 <= (ax2 < bx2) ? ax2 : bx2;
			y2_s1 <= (ay2 < by2) ? ay2 : by2;
		end
	end

	always_comb begin
		dx = x2_s1 - x1_s1;
		dy = y2_s1 - y1_s1;
		if (x1_s1 >= x2_s1 || y1_s1 >= y2_s1) begin
			isect = '0;
		end else begin
			isect.x = x1_s1[COORD_W-1:0];
			isect.y = y1_s1[COORD_W-1:0];
			isect.w = dx[COORD_W-1:0];
			isect.h = dy[COORD_W-1:0];
		end
	end

	assign pop_idx = depth_q - DEPTH_W'(2);

	// stack memory: entry i at address i, entry 0 comes from the screen registers
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem_q[depth_q[ENTRY_AW-1:0]] <= isect;
		end
		if (cmd.pop) begin
			rd_q <= mem_q[pop_idx[ENTRY_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			top_q <= isect;
		end else if (cmd.load) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCREEN_W_RESET;
			scr_h_q <= SCREEN_H_RESET;
			depth_q <= DEPTH_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data;
					CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data;
					default: ;
				endcase
				depth_q <= DEPTH_W'(1);
			end else if (cmd.write) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
		end
	end

	assign depth_ext = {{OUT_DEPTH_W{1'b0}}, depth_q};

	always_comb begin
		rsp.clip_x        = cur.x;
		rsp.clip_y        = cur.y;
		rsp.clip_width    = cur.w;
		rsp.clip_height   = cur.h;
		rsp.clip_nonempty = (cur.w != '0) && (cur.h != '0);
		rsp.stack_depth   = depth_ext[OUT_DEPTH_W-1:0];
		rsp.op_ignored    = cmd.ignored;
	end

endmodule

// ===== src/clip_rectangle_stack.sv =====
// Top level of the clip rectangle stack: controller plus datapath.
//
//  channel   strobe   payload                          direction
//  item      start    req (func, rect_x/y/width/height) in, taken when start && !busy
//  result    done     rsp (clip rectangle, depth, flag) out, one cycle per item
//  config    cfg_we   cfg_index, cfg_data               in, taken every cycle
//
// Read goes from accept straight to done; push passes the intersection's edge
// and write stages, pop the pop and load states (full-stack push and depth-one
// pop go straight to done); a pop waits on the registered stack memory read.
// Reset loads the 1920 x 1080 screen entry and depth one; no clearing pass.
// busy stays high until done; results cannot be stalled.
module clip_rectangle_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  cstk_pkg::req_t                 req,
	output logic                           done,
	output cstk_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [cstk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cstk_pkg::SCREEN_W-1:0]  cfg_data
);
	import cstk_pkg::*;

	cmd_t    cmd;
	status_t status;

	cstk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cstk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.rsp       (rsp)
	);

endmodule
